[src/usrs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and reset values for the ultrasonic sweep range scanner.
// No dependencies.
package usrs_pkg;

  localparam int unsigned ECHO_DIVISOR = 12;
  localparam int unsigned NUM_ANGLES   = 5;
  localparam logic [12:0] DIST_MAX     = 13'd8191;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ECHO    = 3'd1,
    OP_TIMEOUT = 3'd2,
    OP_SCAN    = 3'd3,
    OP_READ    = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    MODE_FAST = 3'b001,
    MODE_DONE = 3'b010,
    MODE_FULL = 3'b100
  } mode_t;

  localparam logic [1:0] SCAN_FAST = 2'd0;
  localparam logic [1:0] SCAN_DONE = 2'd1;
  localparam logic [1:0] SCAN_FULL = 2'd2;

  localparam logic [2:0] REG_POS_0     = 3'd0;
  localparam logic [2:0] REG_POS_45    = 3'd1;
  localparam logic [2:0] REG_POS_90    = 3'd2;
  localparam logic [2:0] REG_POS_135   = 3'd3;
  localparam logic [2:0] REG_POS_180   = 3'd4;
  localparam logic [2:0] REG_SETTLE    = 3'd5;
  localparam logic [2:0] REG_OFFSET    = 3'd6;

  localparam logic [7:0] POS_0_RST      = 8'd35;
  localparam logic [7:0] POS_45_RST     = 8'd28;
  localparam logic [7:0] POS_90_RST     = 8'd22;
  localparam logic [7:0] POS_135_RST    = 8'd15;
  localparam logic [7:0] POS_180_RST    = 8'd9;
  localparam logic [6:0] SETTLE_RST     = 7'd40;
  localparam logic [7:0] OFFSET_RST     = 8'd10;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] echo_ticks;
    logic [2:0]  entry_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  servo_pos;
    logic        trigger;
    logic [12:0] fast_distance;
    logic [1:0]  scan_mode;
    logic        sweep_done;
    logic [12:0] read_value;
  } res_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [NUM_ANGLES-1:0][7:0] pos;
    logic [6:0]                 settle_ticks;
    logic [7:0]                 range_offset;
  } cfg_t;

endpackage

[src/usrs_chan_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload word per handshake.
// Payload type comes from usrs_pkg through the type parameter.
interface usrs_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/usrs_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file: servo angles, settle delay, range offset.
// Depends on usrs_pkg.
module usrs_cfg import usrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  cfg_wr_t wr,
  output cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos[0]       <= POS_0_RST;
      cfg.pos[1]       <= POS_45_RST;
      cfg.pos[2]       <= POS_90_RST;
      cfg.pos[3]       <= POS_135_RST;
      cfg.pos[4]       <= POS_180_RST;
      cfg.settle_ticks <= SETTLE_RST;
      cfg.range_offset <= OFFSET_RST;
    end else if (wr_en) begin
      unique case (wr.index)
        REG_POS_0:   cfg.pos[0] <= wr.value;
        REG_POS_45:  cfg.pos[1] <= wr.value;
        REG_POS_90:  cfg.pos[2] <= wr.value;
        REG_POS_135: cfg.pos[3] <= wr.value;
        REG_POS_180: cfg.pos[4] <= wr.value;
        REG_SETTLE:  cfg.settle_ticks <= wr.value[6:0];
        REG_OFFSET:  cfg.range_offset <= wr.value;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

endmodule

[src/usrs_conv.sv]
`timescale 1ns / 1ps
// Echo width to millimetres: divide by ECHO_DIVISOR, subtract offset, clamp.
// Depends on usrs_pkg.
module usrs_conv import usrs_pkg::*; (
  input  logic [15:0] echo_ticks,
  input  logic [7:0]  range_offset,
  output logic [12:0] mm
);

  // Reciprocal rounded up with a 24-bit shift is exact for all 16-bit inputs
  // and divisors up to 255.
  localparam int unsigned QS = 24;
  localparam longint unsigned RECIP_L = ((64'd1 << QS) + ECHO_DIVISOR - 1) / ECHO_DIVISOR;
  localparam logic [QS:0] RECIP = (QS + 1)'(RECIP_L);

  logic [QS+16:0] prod;
  logic [15:0]    quot;
  logic [15:0]    diff;

  always_comb begin
    prod = (QS + 17)'(echo_ticks) * (QS + 17)'(RECIP);
    quot = prod[QS+15:QS];
    diff = quot - {8'd0, range_offset};
    if (quot < {8'd0, range_offset}) begin
      mm = '0;
    end else if (diff > {3'd0, DIST_MAX}) begin
      mm = DIST_MAX;
    end else begin
      mm = diff[12:0];
    end
  end

endmodule

[src/usrs_ctrl.sv]
`timescale 1ns / 1ps
// Mode control, sweep sequencer, smoothing and scan store; one update per word.
// Depends on usrs_pkg.
module usrs_ctrl import usrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  cmd_t        cmd,
  input  cfg_t        cfg,
  input  logic [12:0] mm,
  output res_t        result
);

  mode_t                       mode, mode_next;
  logic [2:0]                  sweep_step, sweep_step_next;
  logic [7:0]                  settle_count, settle_count_next;
  logic [7:0]                  servo_value, servo_value_next;
  logic                        echo_pending, echo_pending_next;
  logic [12:0]                 smoothed, smoothed_next;
  logic [NUM_ANGLES-1:0][12:0] store, store_next;
  logic [2:0]                  store_slot, store_slot_next;
  logic                        done_flag, done_flag_next;
  logic                        req_pending, req_pending_next;

  logic        fire;
  logic [12:0] rd;
  logic [2:0]  step;
  logic [12:0] echo_val;
  logic [16:0] avg_sum;

  always_comb begin
    mode_next         = mode;
    sweep_step_next   = sweep_step;
    settle_count_next = settle_count;
    servo_value_next  = servo_value;
    echo_pending_next = echo_pending;
    smoothed_next     = smoothed;
    store_next        = store;
    store_slot_next   = store_slot;
    done_flag_next    = done_flag;
    req_pending_next  = req_pending;
    fire              = 1'b0;
    rd                = '0;

    step     = (sweep_step < 3'(NUM_ANGLES)) ? sweep_step : 3'd0;
    echo_val = (cmd.opcode == OP_ECHO) ? mm : 13'd0;
    avg_sum  = ({4'd0, smoothed} << 3) - {4'd0, smoothed} + {4'd0, echo_val};

    unique case (cmd.opcode)
      OP_TICK: begin
        if (mode == MODE_DONE) begin
          if (req_pending) begin
            req_pending_next = 1'b0;
            mode_next        = MODE_FULL;
          end else begin
            mode_next = MODE_FAST;
          end
        end
        if (mode_next == MODE_FAST) begin
          if (!echo_pending) begin
            echo_pending_next = 1'b1;
            fire              = 1'b1;
          end
        end else if (mode_next == MODE_FULL) begin
          // servo move loads the settle delay; long at even angles
          if (servo_value != cfg.pos[step]) begin
            settle_count_next = step[0] ? {1'b0, cfg.settle_ticks}
                                        : {cfg.settle_ticks, 1'b0};
            servo_value_next  = cfg.pos[step];
          end
          if (settle_count_next == 8'd0 && !echo_pending) begin
            if (step == 3'(NUM_ANGLES - 1)) begin
              servo_value_next = cfg.pos[2];
              sweep_step_next  = '0;
              store_slot_next  = '0;
              done_flag_next   = 1'b1;
              mode_next        = MODE_DONE;
            end else begin
              sweep_step_next = step + 3'd1;
              store_slot_next = step + 3'd1;
            end
          end else if (settle_count_next == 8'd1 && !echo_pending) begin
            echo_pending_next = 1'b1;
            fire              = 1'b1;
            settle_count_next = '0;
          end else if (settle_count_next != 8'd0) begin
            settle_count_next = settle_count_next - 8'd1;
          end
        end
      end
      OP_ECHO, OP_TIMEOUT: begin
        if (echo_pending) begin
          echo_pending_next = 1'b0;
          if (mode == MODE_FAST) begin
            smoothed_next = (cmd.opcode == OP_ECHO) ? avg_sum[15:3] : 13'd0;
            mode_next     = MODE_DONE;
          end else if (store_slot < 3'(NUM_ANGLES)) begin
            store_next[store_slot] = echo_val;
          end
        end
      end
      OP_SCAN:  req_pending_next = 1'b1;
      OP_READ: begin
        if (cmd.entry_index < 3'(NUM_ANGLES)) begin
          rd = store[cmd.entry_index];
        end
      end
      OP_CLEAR: done_flag_next = 1'b0;
      default: ;  // unused opcodes
    endcase

    result.servo_pos     = servo_value_next;
    result.trigger       = fire;
    result.fast_distance = smoothed_next;
    unique case (mode_next)
      MODE_FAST: result.scan_mode = SCAN_FAST;
      MODE_DONE: result.scan_mode = SCAN_DONE;
      MODE_FULL: result.scan_mode = SCAN_FULL;
      default:   result.scan_mode = SCAN_FAST;
    endcase
    result.sweep_done    = done_flag_next;
    result.read_value    = rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_FAST;
      sweep_step   <= '0;
      settle_count <= '0;
      servo_value  <= POS_90_RST;
      echo_pending <= 1'b0;
      smoothed     <= '0;
      store        <= '0;
      store_slot   <= '0;
      done_flag    <= 1'b0;
      req_pending  <= 1'b0;
    end else if (en) begin
      mode         <= mode_next;
      sweep_step   <= sweep_step_next;
      settle_count <= settle_count_next;
      servo_value  <= servo_value_next;
      echo_pending <= echo_pending_next;
      smoothed     <= smoothed_next;
      store        <= store_next;
      store_slot   <= store_slot_next;
      done_flag    <= done_flag_next;
      req_pending  <= req_pending_next;
    end
  end

endmodule

[src/ultrasonic_sweep_range_scanner.sv]
`timescale 1ns / 1ps
// Top level of the ultrasonic sweep range scanner.
// Depends on usrs_pkg, usrs_chan_if, usrs_cfg, usrs_conv, usrs_ctrl.
//
// Usage:
//   cmd - one word per event: tick, echo captured (with echo_ticks), echo
//         timeout, full scan request, read entry (with entry_index), clear done.
//   res - exactly one word per cmd word: servo duty, trigger, smoothed
//         distance, scan mode, done flag and the read-back entry.
//   cfg - register writes (index, value), always ready, applied next edge.
//         Write only while no cmd word is in flight.
// Path: a cmd word taken from cmd sits in the input register; its res word
//   is registered once the result register is free and offered from then on.
// Throughput: one word per cycle while res is taken. The whole state update
//   (servo sequencer, echo divide by reciprocal multiply, 7/8 average, store
//   write) is one combinational pass between the input and result registers.
// Reset (rst, synchronous): config returns to its defaults, the ranger is in
//   fast mode with the servo centered, scan store cleared, both channels empty.
// Stall: while res is not taken the result holds; one more cmd word is taken
//   into the input register, then cmd.ready drops until res moves.
module ultrasonic_sweep_range_scanner import usrs_pkg::*; (
  input logic        clk,
  input logic        rst,
  usrs_chan_if.sink   cmd,
  usrs_chan_if.source res,
  usrs_chan_if.sink   cfg
);

  cfg_t        cfg_regs;
  logic        s1_valid;
  cmd_t        s1_cmd;
  logic        adv;
  logic [12:0] mm;
  res_t        res_next;

  // config port never stalls
  assign cfg.ready = 1'b1;

  usrs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg.valid & cfg.ready),
    .wr    (cfg.data),
    .cfg   (cfg_regs)
  );

  // input register advances into the result register when that slot is free
  assign adv       = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_cmd <= cmd.data;
    end
  end

  usrs_conv u_conv (
    .echo_ticks   (s1_cmd.echo_ticks),
    .range_offset (cfg_regs.range_offset),
    .mm           (mm)
  );

  // state commits only when the word moves into the result register
  usrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .cmd    (s1_cmd),
    .cfg    (cfg_regs),
    .mm     (mm),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.data <= res_next;
    end
  end

  // a held input word must not change under a stall
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_cmd))
    else $error("input register changed while stalled");

  // every advanced word shows up as a result
  a_adv_res: assert property (@(posedge clk) disable iff (rst)
    adv |=> res.valid && res.data == $past(res_next))
    else $error("advanced word not presented on res");

  // trigger only fires in fast or sweep mode
  a_trig_mode: assert property (@(posedge clk) disable iff (rst)
    adv && res_next.trigger |-> res_next.scan_mode == SCAN_FAST ||
                                res_next.scan_mode == SCAN_FULL)
    else $error("trigger fired in done mode");

  // read_value is zero unless the word is a read
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    adv && s1_cmd.opcode != OP_READ |-> res_next.read_value == 13'd0)
    else $error("read_value set on a non-read word");

endmodule
